### src/i2crs_pkg.sv
// ----------------------------------------------------------------------------
// i2crs_pkg
// shared types and constants of the i2c register read sequencer
// ----------------------------------------------------------------------------
package i2crs_pkg;

    localparam int unsigned ADDR_W     = 7;
    localparam int unsigned PTR_W      = 8;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned VALUE_W    = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned BIT_CNT_W  = 4;
    localparam int unsigned SUB_W      = 2;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_PTR  = 2'd1;

    localparam logic [ADDR_W-1:0] DEV_ADDR_RESET = 7'd84;
    localparam logic [PTR_W-1:0]  REG_PTR_RESET  = 8'd0;

    localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE = 4'd8;

    // one bus slot as driven by the sequencer
    typedef struct packed {
        logic               scl_level;
        logic               sda_level;
        logic               busy_res;
        logic               done_res;
        logic [VALUE_W-1:0] read_value;
    } t_slot;

endpackage

### src/i2crs_item_if.sv
// ----------------------------------------------------------------------------
// i2crs_item_if
// input channel: one bus slot request per beat
// ----------------------------------------------------------------------------
interface i2crs_item_if;
    logic valid;
    logic ready;
    logic start_request;
    logic sda_in;

    modport source (output valid, output start_request, output sda_in, input ready);
    modport sink   (input valid, input start_request, input sda_in, output ready);
endinterface

### src/i2crs_res_if.sv
// ----------------------------------------------------------------------------
// i2crs_res_if
// result channel: driven bus levels and status per beat
// ----------------------------------------------------------------------------
interface i2crs_res_if
    import i2crs_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               scl_level;
    logic               sda_level;
    logic               busy_res;
    logic               done_res;
    logic [VALUE_W-1:0] read_value;

    modport source (output valid, output scl_level, output sda_level, output busy_res,
                    output done_res, output read_value, input ready);
    modport sink   (input valid, input scl_level, input sda_level, input busy_res,
                    input done_res, input read_value, output ready);
endinterface

### src/i2crs_cfg_if.sv
// ----------------------------------------------------------------------------
// i2crs_cfg_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
interface i2crs_cfg_if
    import i2crs_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### src/i2crs_seq.sv
// ----------------------------------------------------------------------------
// i2crs_seq
// bus sequencer: segment state, bit counter, shift byte and read result
// ----------------------------------------------------------------------------
module i2crs_seq
    import i2crs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_start,
    input  logic              i_sda,
    input  logic [ADDR_W-1:0] i_dev_addr,
    input  logic [PTR_W-1:0]  i_reg_ptr,
    output t_slot             o_slot
);

    typedef enum logic [13:0] {
        SEG_IDLE   = 14'h0001,
        SEG_START  = 14'h0002,
        SEG_ADDRW  = 14'h0004,
        SEG_ACK1   = 14'h0008,
        SEG_REGP   = 14'h0010,
        SEG_ACK2   = 14'h0020,
        SEG_RSTART = 14'h0040,
        SEG_ADDRR  = 14'h0080,
        SEG_ACK3   = 14'h0100,
        SEG_RD1    = 14'h0200,
        SEG_MACK   = 14'h0400,
        SEG_RD2    = 14'h0800,
        SEG_MNACK  = 14'h1000,
        SEG_STOP   = 14'h2000
    } t_seg;

    function automatic t_seg next_seg(input t_seg s);
        t_seg r;
        unique case (s)
            SEG_START:  r = SEG_ADDRW;
            SEG_ADDRW:  r = SEG_ACK1;
            SEG_ACK1:   r = SEG_REGP;
            SEG_REGP:   r = SEG_ACK2;
            SEG_ACK2:   r = SEG_RSTART;
            SEG_RSTART: r = SEG_ADDRR;
            SEG_ADDRR:  r = SEG_ACK3;
            SEG_ACK3:   r = SEG_RD1;
            SEG_RD1:    r = SEG_MACK;
            SEG_MACK:   r = SEG_RD2;
            SEG_RD2:    r = SEG_MNACK;
            SEG_MNACK:  r = SEG_STOP;
            default:    r = SEG_IDLE;
        endcase
        return r;
    endfunction

    t_seg                 r_seg, n_seg;
    logic [SUB_W-1:0]     r_sub, n_sub;
    logic [BIT_CNT_W-1:0] r_bit_cnt, n_bit_cnt;
    logic [BYTE_W-1:0]    r_shift, n_shift;
    logic [VALUE_W-1:0]   r_result, n_result;
    logic                 r_scl, n_scl;
    logic                 r_sda, n_sda;

    t_seg                 seg, nxt;
    logic [SUB_W-1:0]     sub;
    logic [BIT_CNT_W-1:0] bit_cnt;
    logic [BYTE_W-1:0]    shift;
    logic                 scl, sda, last, done, per_bit, run;

    always_comb begin
        n_seg     = r_seg;
        n_sub     = r_sub;
        n_bit_cnt = r_bit_cnt;
        n_shift   = r_shift;
        n_result  = r_result;
        n_scl     = r_scl;
        n_sda     = r_sda;
        seg       = r_seg;
        sub       = r_sub;
        bit_cnt   = r_bit_cnt;
        shift     = r_shift;
        scl       = 1'b0;
        sda       = 1'b1;
        last      = 1'b0;
        done      = 1'b0;
        per_bit   = 1'b0;
        run       = 1'b1;
        nxt       = SEG_IDLE;

        // a start in idle runs the first start slot in this same step
        if (r_seg == SEG_IDLE) begin
            if (!i_start) begin
                run = 1'b0;
            end else begin
                seg     = SEG_START;
                sub     = '0;
                bit_cnt = '0;
            end
        end

        unique case (seg)
            SEG_START, SEG_RSTART: begin
                scl  = (sub == 2'd0) ? r_scl : (sub != 2'd3);
                sda  = (sub < 2'd2);
                last = (sub == 2'd3);
            end
            SEG_ADDRW, SEG_REGP, SEG_ADDRR: begin
                per_bit = 1'b1;
                scl     = (sub == 2'd1);
                sda     = shift[BYTE_W-1];
                if (sub == 2'd2) begin
                    shift   = {shift[BYTE_W-2:0], 1'b0};
                    bit_cnt = bit_cnt + 1'b1;
                    last    = (bit_cnt >= BITS_PER_BYTE);
                end
            end
            SEG_RD1, SEG_RD2: begin
                per_bit = 1'b1;
                scl     = (sub < 2'd2);
                sda     = 1'b1;
                if (sub == 2'd0) begin
                    shift = {shift[BYTE_W-2:0], i_sda};
                end
                if (sub == 2'd2) begin
                    bit_cnt = bit_cnt + 1'b1;
                    if (bit_cnt >= BITS_PER_BYTE) begin
                        last = 1'b1;
                        if (seg == SEG_RD1) begin
                            n_result = {shift, r_result[BYTE_W-1:0]};
                        end else begin
                            n_result = {r_result[VALUE_W-1:BYTE_W], shift};
                        end
                    end
                end
            end
            SEG_ACK1, SEG_ACK2, SEG_ACK3: begin
                scl  = (sub == 2'd1);
                sda  = 1'b1;
                last = (sub == 2'd3);
            end
            SEG_MACK: begin
                scl  = (sub == 2'd1);
                sda  = (sub == 2'd3);
                last = (sub == 2'd3);
            end
            SEG_MNACK: begin
                scl  = (sub == 2'd1);
                sda  = (sub != 2'd3);
                last = (sub == 2'd3);
            end
            SEG_STOP: begin
                scl  = (sub >= 2'd1);
                sda  = (sub >= 2'd2);
                last = (sub >= 2'd2);
            end
            default: begin
                scl = r_scl;
                sda = r_sda;
            end
        endcase

        if (run) begin
            n_scl = scl;
            n_sda = sda;
            if (last) begin
                n_sub     = '0;
                n_bit_cnt = '0;
                n_shift   = shift;
                if (seg == SEG_STOP) begin
                    n_seg = SEG_IDLE;
                    done  = 1'b1;
                end else begin
                    nxt   = next_seg(seg);
                    n_seg = nxt;
                    // outgoing bytes latch the config at segment entry
                    unique case (nxt)
                        SEG_ADDRW:        n_shift = {i_dev_addr, 1'b0};
                        SEG_REGP:         n_shift = i_reg_ptr;
                        SEG_ADDRR:        n_shift = {i_dev_addr, 1'b1};
                        SEG_RD1, SEG_RD2: n_shift = '0;
                        default:          n_shift = shift;
                    endcase
                end
            end else begin
                n_seg     = seg;
                n_bit_cnt = bit_cnt;
                n_shift   = shift;
                n_sub     = (per_bit && sub >= 2'd2) ? '0 : sub + 1'b1;
            end
        end

        o_slot.scl_level  = run ? scl : r_scl;
        o_slot.sda_level  = run ? sda : r_sda;
        o_slot.busy_res   = run;
        o_slot.done_res   = done;
        o_slot.read_value = done ? n_result : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg     <= SEG_IDLE;
            r_sub     <= '0;
            r_bit_cnt <= '0;
            r_shift   <= '0;
            r_result  <= '0;
            r_scl     <= 1'b1;
            r_sda     <= 1'b1;
        end else if (i_step) begin
            r_seg     <= n_seg;
            r_sub     <= n_sub;
            r_bit_cnt <= n_bit_cnt;
            r_shift   <= n_shift;
            r_result  <= n_result;
            r_scl     <= n_scl;
            r_sda     <= n_sda;
        end
    end

    // done only comes out of the stop segment and drops back to idle
    a_done_in_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_slot.done_res) |-> (r_seg == SEG_STOP))
        else $error("done outside stop segment");

    a_idle_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_slot.done_res) |=> (r_seg == SEG_IDLE))
        else $error("sequencer not idle after done");

    a_bit_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_cnt <= BITS_PER_BYTE)
        else $error("bit counter past one byte");

    a_hold_no_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> ($stable(r_seg) && $stable(r_sub) && $stable(r_result)))
        else $error("sequencer moved without a beat");

endmodule

### src/i2c_register_read_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_register_read_sequencer
// bit-level i2c master running one fixed two-byte register read per start
// ----------------------------------------------------------------------------
//
// channel    dir  handshake      payload
// i_item     in   valid/ready    start_request, sda_in (one bus slot per beat)
// o_result   out  valid/ready    scl_level, sda_level, busy_res, done_res, read_value
// i_cfg      in   valid/ready    index (0 device_address, 1 register_pointer), data
//
// one input beat gives one result beat; a beat can be taken every cycle unless the sink stalls
// each slot is computed combinationally from the sequencer state and lands in the
// result register, which is the only stage between the two channels
// a new beat is accepted while the result register is empty or being drained,
// so a stalled sink holds one result and then stalls the source
// a full transaction is 151 slots from the start beat to the done beat
// i_rst_n (synchronous) clears the sequencer to idle with both lines high and
// loads the config registers with address 84 and pointer 0
// ----------------------------------------------------------------------------
module i2c_register_read_sequencer
    import i2crs_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    i2crs_item_if.sink   i_item,
    i2crs_res_if.source  o_result,
    i2crs_cfg_if.sink    i_cfg
);

    // config registers, sampled by the sequencer when a byte send begins
    logic [ADDR_W-1:0] r_dev_addr;
    logic [PTR_W-1:0]  r_reg_ptr;

    // result register
    logic  r_out_valid, n_out_valid;
    t_slot r_out;

    t_slot slot;
    logic  accept;

    assign i_item.ready = !r_out_valid || o_result.ready;
    assign accept       = i_item.valid && i_item.ready;

    i2crs_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (accept),
        .i_start    (i_item.start_request),
        .i_sda      (i_item.sda_in),
        .i_dev_addr (r_dev_addr),
        .i_reg_ptr  (r_reg_ptr),
        .o_slot     (slot)
    );

    // output beat leaves when taken, new beat overwrites in the same cycle
    always_comb begin
        if (accept) begin
            n_out_valid = 1'b1;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= slot;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.scl_level  = r_out.scl_level;
    assign o_result.sda_level  = r_out.sda_level;
    assign o_result.busy_res   = r_out.busy_res;
    assign o_result.done_res   = r_out.done_res;
    assign o_result.read_value = r_out.read_value;

    // config writes are always taken; unknown indexes are dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= DEV_ADDR_RESET;
            r_reg_ptr  <= REG_PTR_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_DEV_ADDR: r_dev_addr <= i_cfg.data[ADDR_W-1:0];
                CFG_REG_PTR:  r_reg_ptr  <= i_cfg.data[PTR_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

### tb/sv/i2crs_checker.sv
// ----------------------------------------------------------------------------
// i2crs_checker
// predicts every bus slot of the register read sequencer and compares the
// result beats against it in order
// ----------------------------------------------------------------------------
module i2crs_checker
    import i2crs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    i2crs_item_if  item_ch,
    i2crs_res_if   res_ch,
    i2crs_cfg_if   cfg_ch,
    output int     o_fail_count,
    output int     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // transaction segments in bus order
    typedef enum logic [3:0] {
        SEG_IDLE, SEG_START, SEG_ADDR_WR, SEG_ACK_ADDR_WR, SEG_PTR, SEG_ACK_PTR,
        SEG_RSTART, SEG_ADDR_RD, SEG_ACK_ADDR_RD, SEG_READ_HI, SEG_MACK,
        SEG_READ_LO, SEG_MNACK, SEG_STOP
    } t_bus_seg;

    t_bus_seg             seg_q;
    logic [SUB_W-1:0]     sub_q;
    logic [BIT_CNT_W-1:0] bits_done;
    logic [BYTE_W-1:0]    shreg;
    logic [VALUE_W-1:0]   rd_word;
    logic                 scl_q;
    logic                 sda_q;
    logic [ADDR_W-1:0]    dev_addr;
    logic [PTR_W-1:0]     reg_ptr;

    t_slot pending_slots[$];
    int    fail_cnt = 0;
    int    pend_cnt = 0;

    assign o_fail_count = fail_cnt;
    assign o_pending    = pend_cnt;

    function automatic void reset_sequencer();
        seg_q     = SEG_IDLE;
        sub_q     = '0;
        bits_done = '0;
        shreg     = '0;
        rd_word   = '0;
        scl_q     = 1'b1;
        sda_q     = 1'b1;
        dev_addr  = DEV_ADDR_RESET;
        reg_ptr   = REG_PTR_RESET;
    endfunction

    // outgoing bytes are latched here, at segment entry
    function automatic void enter_seg(t_bus_seg s);
        seg_q     = s;
        sub_q     = '0;
        bits_done = '0;
        case (s)
            SEG_ADDR_WR: shreg = {dev_addr, 1'b0};
            SEG_PTR:     shreg = reg_ptr;
            SEG_ADDR_RD: shreg = {dev_addr, 1'b1};
            SEG_READ_HI,
            SEG_READ_LO: shreg = '0;
            default: ;
        endcase
    endfunction

    function automatic t_slot bus_slot_for(input logic start_req, input logic sda_seen);
        t_slot r;
        logic  scl;
        logic  sda;
        logic  last;
        logic  per_bit;
        r       = '0;
        scl     = 1'b0;
        sda     = 1'b1;
        last    = 1'b0;
        per_bit = 1'b0;
        if (seg_q == SEG_IDLE) begin
            if (!start_req) begin
                sub_q       = '0;
                r.scl_level = scl_q;
                r.sda_level = sda_q;
                return r;
            end
            enter_seg(SEG_START);
        end
        case (seg_q)
            SEG_START, SEG_RSTART: begin
                scl  = (sub_q == 2'd0) ? scl_q : (sub_q < 2'd3);
                sda  = (sub_q < 2'd2);
                last = (sub_q == 2'd3);
            end
            SEG_ADDR_WR, SEG_PTR, SEG_ADDR_RD: begin
                per_bit = 1'b1;
                scl     = (sub_q == 2'd1);
                sda     = shreg[BYTE_W-1];
                if (sub_q == 2'd2) begin
                    shreg     = shreg << 1;
                    bits_done = bits_done + 1'b1;
                    last      = (bits_done >= BITS_PER_BYTE);
                end
            end
            SEG_READ_HI, SEG_READ_LO: begin
                per_bit = 1'b1;
                scl     = (sub_q < 2'd2);
                sda     = 1'b1;
                // data line is sampled in the first slot of each bit
                if (sub_q == 2'd0)
                    shreg = {shreg[BYTE_W-2:0], sda_seen};
                if (sub_q == 2'd2) begin
                    bits_done = bits_done + 1'b1;
                    if (bits_done >= BITS_PER_BYTE) begin
                        last = 1'b1;
                        if (seg_q == SEG_READ_HI)
                            rd_word[15:8] = shreg;
                        else
                            rd_word[7:0] = shreg;
                    end
                end
            end
            SEG_MACK: begin
                scl  = (sub_q == 2'd1);
                sda  = (sub_q == 2'd3);
                last = (sub_q == 2'd3);
            end
            SEG_MNACK: begin
                scl  = (sub_q == 2'd1);
                sda  = (sub_q != 2'd3);
                last = (sub_q == 2'd3);
            end
            SEG_STOP: begin
                scl  = (sub_q >= 2'd1);
                sda  = (sub_q >= 2'd2);
                last = (sub_q >= 2'd2);
            end
            default: begin
                // target ack slots, line released and not looked at
                scl  = (sub_q == 2'd1);
                sda  = 1'b1;
                last = (sub_q == 2'd3);
            end
        endcase
        scl_q = scl;
        sda_q = sda;
        r.scl_level = scl;
        r.sda_level = sda;
        r.busy_res  = 1'b1;
        if (last) begin
            if (seg_q == SEG_STOP) begin
                seg_q        = SEG_IDLE;
                sub_q        = '0;
                r.done_res   = 1'b1;
                r.read_value = rd_word;
            end else begin
                enter_seg(t_bus_seg'(seg_q + 1'b1));
            end
        end else if (per_bit && sub_q == 2'd2) begin
            sub_q = '0;
        end else begin
            sub_q = sub_q + 1'b1;
        end
        return r;
    endfunction

    function automatic void compare_field(string name, logic [VALUE_W-1:0] want,
                                          logic [VALUE_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_cnt++;
        end
    endfunction

    function automatic void check_result_beat();
        t_slot want;
        if (pending_slots.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual scl %0b sda %0b",
                     $time, res_ch.scl_level, res_ch.sda_level);
            fail_cnt++;
            return;
        end
        want = pending_slots.pop_front();
        compare_field("scl_level", VALUE_W'(want.scl_level), VALUE_W'(res_ch.scl_level));
        compare_field("sda_level", VALUE_W'(want.sda_level), VALUE_W'(res_ch.sda_level));
        compare_field("busy_res", VALUE_W'(want.busy_res), VALUE_W'(res_ch.busy_res));
        compare_field("done_res", VALUE_W'(want.done_res), VALUE_W'(res_ch.done_res));
        compare_field("read_value", want.read_value, res_ch.read_value);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_sequencer();
            pending_slots.delete();
        end else begin
            // a result leaving now always belongs to an earlier slot
            if (res_ch.valid && res_ch.ready)
                check_result_beat();
            if (item_ch.valid && item_ch.ready)
                pending_slots.push_back(bus_slot_for(item_ch.start_request, item_ch.sda_in));
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (cfg_ch.index == CFG_DEV_ADDR)
                    dev_addr = cfg_ch.data[ADDR_W-1:0];
                else if (cfg_ch.index == CFG_REG_PTR)
                    reg_ptr = cfg_ch.data;
            end
        end
        pend_cnt = pending_slots.size();
    end

endmodule

### tb/sv/tb_i2c_register_read_sequencer.sv
// ----------------------------------------------------------------------------
// tb_i2c_register_read_sequencer
// drives bus slots and register writes into the read sequencer, with bursty
// input, a stalling result sink and config changes between and inside
// transactions; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module tb_i2c_register_read_sequencer
    import i2crs_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // slots of one full read, start beat to done beat
    localparam int READ_SLOTS    = 151;
    // first sampling slot of each read byte, one sample every three slots
    localparam int READ_HI_FIRST = 92;
    localparam int READ_LO_FIRST = 120;
    localparam int ITEM_TARGET   = 1700;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_LIMIT   = 10000;

    // indexes past the register list, the block must ignore them
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE0 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE1 = 2'd3;

    typedef struct {
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
    } t_reg_write;

    logic i_clk = 1'b0;
    logic i_rst_n;

    i2crs_item_if item_ch();
    i2crs_res_if  res_ch();
    i2crs_cfg_if  cfg_ch();

    int fail_count;
    int pending;

    t_reg_write  reg_writes[$];
    int unsigned burst_left = 0;
    bit          gaps_on = 1'b1;
    int          items_sent = 0;
    bit          long_hold_req = 1'b0;
    bit          long_hold_done = 1'b0;

    always #1 i_clk = ~i_clk;

    i2c_register_read_sequencer DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (res_ch),
        .i_cfg    (cfg_ch)
    );

    i2crs_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .item_ch      (item_ch),
        .res_ch       (res_ch),
        .cfg_ch       (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // one slot beat; gaps only open at burst boundaries
    // entered and left at a falling edge
    task automatic send_slot(input logic start_req, input logic sda_bit);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = gaps_on ? $urandom_range(0, 8) : 0;
            if (gap != 0) begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        item_ch.valid         <= 1'b1;
        item_ch.start_request <= start_req;
        item_ch.sda_in        <= sda_bit;
        do @(posedge i_clk); while (!item_ch.ready);
        @(negedge i_clk);
        burst_left--;
        items_sent++;
    endtask

    // stop offering slots until every predicted slot has come back
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // back-to-back config beats, valid stays high between them
    task automatic apply_reg_writes();
        t_reg_write w;
        while (reg_writes.size() != 0) begin
            w = reg_writes.pop_front();
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= w.reg_idx;
            cfg_ch.data  <= w.reg_data;
            do @(posedge i_clk); while (!cfg_ch.ready);
            @(negedge i_clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic queue_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] dat);
        t_reg_write w;
        w.reg_idx  = idx;
        w.reg_data = dat;
        reg_writes.push_back(w);
    endtask

    // one full register read; the target answers rd_val on its sampling slots
    // busy_start: 0 start low while busy, 1 start high, 2 random
    // addr_at / ptr_at: slot before which the transfer pauses for a write, -1 none
    task automatic run_read(input logic [VALUE_W-1:0] rd_val, input int busy_start,
                            input int addr_at, input logic [CFG_DATA_W-1:0] addr_val,
                            input int ptr_at, input logic [CFG_DATA_W-1:0] ptr_val);
        logic start_req;
        logic sda_bit;
        for (int j = 0; j < READ_SLOTS; j++) begin
            if (j == addr_at)
                queue_write(CFG_DEV_ADDR, addr_val);
            if (j == ptr_at)
                queue_write(CFG_REG_PTR, ptr_val);
            if (reg_writes.size() != 0) begin
                // write lands mid-transaction, with no slot in flight
                wait_drained();
                apply_reg_writes();
            end
            case (busy_start)
                0:       start_req = 1'b0;
                1:       start_req = 1'b1;
                default: start_req = 1'($urandom_range(0, 1));
            endcase
            if (j == 0)
                start_req = 1'b1;
            sda_bit = 1'($urandom_range(0, 1));
            if (j >= READ_HI_FIRST && j < READ_HI_FIRST + 24 && (j - READ_HI_FIRST) % 3 == 0)
                sda_bit = rd_val[15 - (j - READ_HI_FIRST) / 3];
            else if (j >= READ_LO_FIRST && j < READ_LO_FIRST + 24 &&
                     (j - READ_LO_FIRST) % 3 == 0)
                sda_bit = rd_val[7 - (j - READ_LO_FIRST) / 3];
            send_slot(start_req, sda_bit);
        end
    endtask

    function automatic logic [VALUE_W-1:0] pick_read_word();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8001;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_addr();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'h7F;
            2:       return 8'hFF;   // top bit must be dropped
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_ptr();
        case ($urandom_range(0, 2))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // result sink: stretches of steady ready, light stall or heavy stall,
    // plus one long hold-off on request
    initial begin
        int unsigned mode;
        int unsigned len;
        res_ch.ready = 1'b0;
        forever begin
            if (long_hold_req && !long_hold_done) begin
                @(negedge i_clk);
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                long_hold_done = 1'b1;
            end else begin
                mode = $urandom_range(0, 2);
                len  = $urandom_range(8, 64);
                for (int k = 0; k < len && !(long_hold_req && !long_hold_done); k++) begin
                    @(negedge i_clk);
                    case (mode)
                        0:       res_ch.ready <= 1'b1;
                        1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
                        default: res_ch.ready <= ($urandom_range(0, 3) == 0);
                    endcase
                end
            end
        end
    end

    // hard stop for a hung handshake
    initial begin
        #1_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        int n_reads;
        int phase_idx;
        int addr_at;
        int ptr_at;
        int drain_cycles;
        item_ch.valid         = 1'b0;
        item_ch.start_request = 1'b0;
        item_ch.sda_in        = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = CFG_DEV_ADDR;
        cfg_ch.data           = '0;
        i_rst_n               = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // idle slots: lines hold high, data line ignored
        for (int i = 0; i < 4; i++)
            send_slot(1'b0, 1'(i));

        // lowest address, highest pointer, target returns all zeros,
        // start held high the whole way to show it is ignored while busy
        queue_write(CFG_DEV_ADDR, 8'h00);
        queue_write(CFG_REG_PTR, 8'hFF);
        wait_drained();
        apply_reg_writes();
        run_read(16'h0000, 1, -1, '0, -1, '0);

        // highest address through an oversized write, pointer zero,
        // spare indexes must leave both registers alone
        queue_write(CFG_DEV_ADDR, 8'hFF);
        queue_write(CFG_REG_PTR, 8'h00);
        queue_write(CFG_IDX_SPARE0, 8'h5A);
        queue_write(CFG_IDX_SPARE1, 8'hA5);
        wait_drained();
        apply_reg_writes();
        run_read(16'hFFFF, 0, -1, '0, -1, '0);

        // back to back with the previous read; address changes before the
        // read address byte is latched, pointer after its byte was latched
        run_read(16'hA55A, 2, 30, 8'h2B, 40, 8'h5A);

        // random phases: new settings, then one or two reads
        phase_idx = 0;
        while (items_sent < ITEM_TARGET) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) == 0)
                queue_write($urandom_range(0, 1) ? CFG_IDX_SPARE0 : CFG_IDX_SPARE1,
                            8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1)) begin
                queue_write(CFG_DEV_ADDR, pick_addr());
                queue_write(CFG_REG_PTR, pick_ptr());
            end else begin
                queue_write(CFG_REG_PTR, pick_ptr());
                queue_write(CFG_DEV_ADDR, pick_addr());
            end
            wait_drained();
            apply_reg_writes();
            if (phase_idx == 1) begin
                // sender streams without gaps while the sink holds off
                gaps_on       = 1'b0;
                long_hold_req = 1'b1;
            end
            n_reads = $urandom_range(1, 2);
            for (int r = 0; r < n_reads; r++) begin
                repeat ($urandom_range(0, 4))
                    send_slot(1'b0, 1'($urandom_range(0, 1)));
                addr_at = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, READ_SLOTS - 1)) : -1;
                ptr_at  = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, READ_SLOTS - 1)) : -1;
                run_read(pick_read_word(), 2, addr_at, pick_addr(), ptr_at, pick_ptr());
            end
            phase_idx++;
        end

        // let the last slots come back
        item_ch.valid <= 1'b0;
        drain_cycles = 0;
        while (pending != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(negedge i_clk);
            drain_cycles++;
        end
        repeat (4) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
